// File: src/point_in_triangle_projected_macros.svh
// Assertion macros shared by the point-in-triangle checker.
`ifndef POINT_IN_TRIANGLE_PROJECTED_MACROS_SVH
`define POINT_IN_TRIANGLE_PROJECTED_MACROS_SVH

// Concurrent assertion that is clocked on clk_i and idle while reset is low.
`define PTIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// File: src/ptip_pkg.sv
// Types and constants of the projected point-in-triangle test.
package ptip_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
    vec_t p;
  } tri_t;

  localparam logic [1:0] PLANE_YZ = 2'd0;
  localparam logic [1:0] PLANE_XZ = 2'd1;
  localparam logic [1:0] PLANE_XY = 2'd2;

  localparam int NumStages = 14;

  localparam logic [30:0] TolReset = 31'd7;

endpackage

// File: src/point_in_triangle_projected.sv
// Top level: pipelined projected point-in-triangle test.
// Throughput: one request per cycle; busy_o stays low because nothing stalls.
// The depth is set by the squared normal and the tolerance product, each split into
// 31- to 33-bit partial products summed over later stages, and by the edge compare.
// Reset clears all valid bits and sets the tolerance to 7; payload is not reset.
module point_in_triangle_projected
  import ptip_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic         tolerance_we_i,
  input  logic [30:0]  tolerance_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic         valid_o,
  output logic         inside_res_o,
  output logic         on_edge_o,
  output logic [1:0]   plane_used_o
);

  logic [30:0] tol_q;
  logic [NumStages-1:0] v_q, v_d;

  tri_t tri_q [NumStages-3];
  tri_t tri_in, tri_k;

  logic signed [32:0] e1_b_q [3];
  logic signed [32:0] e2_b_q [3];
  logic signed [32:0] e1_d [3];
  logic signed [32:0] e2_d [3];
  logic signed [65:0] prod_c_q [6];
  logic signed [65:0] prod_d [6];
  logic [64:0] nabs_d [3], nabs_d_q [3];
  logic [65:0] pp_hh_d [3], pp_hh_e_q [3];
  logic [64:0] pp_hl_d [3], pp_hl_e_q [3];
  logic [63:0] pp_ll_d [3], pp_ll_e_q [3];
  logic [129:0] sq_d [3], sq_f_q [3];
  logic [131:0] n2_d, n2_g_q;
  logic [61:0] tsq_d, tsq_g_q;
  logic [129:0] sq0_g_q, sq1_g_q, sq0_h_q, sq1_h_q;
  logic [129:0] sq0_i_q, sq1_i_q, sq0_j_q, sq1_j_q;
  logic [63:0] rpp_d [8], rpp_h_q [8];
  logic [162:0] rs0_d, rs1_d, rs0_i_q, rs1_i_q;
  logic [197:0] rhs_d, rhs_j_q;
  logic [1:0] plane_k_q, plane_d;
  logic [1:0] plane_l_q, plane_m_q;

  logic signed [31:0] rr [3];
  logic signed [31:0] hh [3];
  logic signed [31:0] pr, ph;

  logic signed [32:0] dh_d [3], dr_d [3], dd [3];
  logic [32:0] ad [3];
  logic signed [34:0] upk_d [3], dnk_d [3];
  logic use_d [3], neg_d [3];

  logic signed [32:0] dh_l_q [3], dr_l_q [3];
  logic [32:0] ad_l_q [3];
  logic signed [34:0] upk_l_q [3], dnk_l_q [3];
  logic use_l_q [3], neg_l_q [3];

  logic signed [65:0] lhs_m_q [3];
  logic signed [69:0] up_m_q [3], dn_m_q [3];
  logic use_m_q [3], neg_m_q [3];

  logic signed [69:0] lhs_k [3];
  logic up_k, dn_k, on_k;
  logic inside_d, on_d;

  assign busy_o = 1'b0;

  assign tri_in = '{a: '{x: a_x_i, y: a_y_i, z: a_z_i},
                    b: '{x: b_x_i, y: b_y_i, z: b_z_i},
                    c: '{x: c_x_i, y: c_y_i, z: c_z_i},
                    p: '{x: point_x_i, y: point_y_i, z: point_z_i}};

  assign tri_k = tri_q[NumStages-4];

  assign v_d = {v_q[NumStages-2:0], start_i & ~busy_o};

  always_comb begin
    e1_d[0] = {tri_q[0].b.x[31], tri_q[0].b.x} - {tri_q[0].a.x[31], tri_q[0].a.x};
    e1_d[1] = {tri_q[0].b.y[31], tri_q[0].b.y} - {tri_q[0].a.y[31], tri_q[0].a.y};
    e1_d[2] = {tri_q[0].b.z[31], tri_q[0].b.z} - {tri_q[0].a.z[31], tri_q[0].a.z};
    e2_d[0] = {tri_q[0].c.x[31], tri_q[0].c.x} - {tri_q[0].a.x[31], tri_q[0].a.x};
    e2_d[1] = {tri_q[0].c.y[31], tri_q[0].c.y} - {tri_q[0].a.y[31], tri_q[0].a.y};
    e2_d[2] = {tri_q[0].c.z[31], tri_q[0].c.z} - {tri_q[0].a.z[31], tri_q[0].a.z};
  end

  always_comb begin
    prod_d[0] = e1_b_q[1] * e2_b_q[2];
    prod_d[1] = e1_b_q[2] * e2_b_q[1];
    prod_d[2] = e1_b_q[2] * e2_b_q[0];
    prod_d[3] = e1_b_q[0] * e2_b_q[2];
    prod_d[4] = e1_b_q[0] * e2_b_q[1];
    prod_d[5] = e1_b_q[1] * e2_b_q[0];
  end

  // The magnitude of each normal component is squared from 33-bit and 32-bit halves.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (prod_c_q[2*i] >= prod_c_q[2*i+1]) begin
        nabs_d[i] = 65'(prod_c_q[2*i] - prod_c_q[2*i+1]);
      end else begin
        nabs_d[i] = 65'(prod_c_q[2*i+1] - prod_c_q[2*i]);
      end
      pp_hh_d[i] = {33'd0, nabs_d_q[i][64:32]} * {33'd0, nabs_d_q[i][64:32]};
      pp_hl_d[i] = {32'd0, nabs_d_q[i][64:32]} * {33'd0, nabs_d_q[i][31:0]};
      pp_ll_d[i] = {32'd0, nabs_d_q[i][31:0]} * {32'd0, nabs_d_q[i][31:0]};
      sq_d[i] = {pp_hh_e_q[i], 64'd0} + {32'd0, pp_hl_e_q[i], 33'd0} +
                {66'd0, pp_ll_e_q[i]};
    end
  end

  assign n2_d = {2'b00, sq_f_q[0]} + {2'b00, sq_f_q[1]} + {2'b00, sq_f_q[2]};
  assign tsq_d = {31'd0, tol_q} * {31'd0, tol_q};

  // The tolerance product is built from 31-bit by 33-bit partial products.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rpp_d[b]   = {33'd0, tsq_g_q[30:0]} * {31'd0, n2_g_q[33*b +: 33]};
      rpp_d[4+b] = {33'd0, tsq_g_q[61:31]} * {31'd0, n2_g_q[33*b +: 33]};
    end
  end

  assign rs0_d = {99'd0, rpp_h_q[0]} + {66'd0, rpp_h_q[1], 33'd0} +
                 {33'd0, rpp_h_q[2], 66'd0} + {rpp_h_q[3], 99'd0};
  assign rs1_d = {99'd0, rpp_h_q[4]} + {66'd0, rpp_h_q[5], 33'd0} +
                 {33'd0, rpp_h_q[6], 66'd0} + {rpp_h_q[7], 99'd0};
  assign rhs_d = {35'd0, rs0_i_q} + {4'd0, rs1_i_q, 31'd0};

  always_comb begin
    if ({36'd0, sq0_j_q, 32'd0} > rhs_j_q) begin
      plane_d = PLANE_YZ;
    end else if ({36'd0, sq1_j_q, 32'd0} > rhs_j_q) begin
      plane_d = PLANE_XZ;
    end else begin
      plane_d = PLANE_XY;
    end
  end

  always_comb begin
    case (plane_k_q)
      PLANE_YZ: begin
        rr = '{tri_k.a.y, tri_k.b.y, tri_k.c.y};
        hh = '{tri_k.a.z, tri_k.b.z, tri_k.c.z};
        pr = tri_k.p.y;
        ph = tri_k.p.z;
      end
      PLANE_XZ: begin
        rr = '{tri_k.a.x, tri_k.b.x, tri_k.c.x};
        hh = '{tri_k.a.z, tri_k.b.z, tri_k.c.z};
        pr = tri_k.p.x;
        ph = tri_k.p.z;
      end
      default: begin
        rr = '{tri_k.a.x, tri_k.b.x, tri_k.c.x};
        hh = '{tri_k.a.y, tri_k.b.y, tri_k.c.y};
        pr = tri_k.p.x;
        ph = tri_k.p.y;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      dd[i] = {rr[(i+1)%3][31], rr[(i+1)%3]} - {rr[i][31], rr[i]};
      ad[i] = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
      neg_d[i] = dd[i][32];
      use_d[i] = (ad[i] > {2'b00, tol_q}) &&
                 (((pr >= rr[i]) && (pr <= rr[(i+1)%3])) ||
                  ((pr <= rr[i]) && (pr >= rr[(i+1)%3])));
      dh_d[i] = {hh[(i+1)%3][31], hh[(i+1)%3]} - {hh[i][31], hh[i]};
      dr_d[i] = {pr[31], pr} - {rr[i][31], rr[i]};
      upk_d[i] = {{3{ph[31]}}, ph} + $signed({4'd0, tol_q}) - {{3{hh[i][31]}}, hh[i]};
      dnk_d[i] = {{3{ph[31]}}, ph} - $signed({4'd0, tol_q}) - {{3{hh[i][31]}}, hh[i]};
    end
  end

  always_comb begin
    up_k = 1'b0;
    dn_k = 1'b0;
    on_k = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lhs_k[i] = neg_m_q[i] ? -{{4{lhs_m_q[i][65]}}, lhs_m_q[i]}
                            : {{4{lhs_m_q[i][65]}}, lhs_m_q[i]};
      if (use_m_q[i]) begin
        if (lhs_k[i] > up_m_q[i]) begin
          up_k = 1'b1;
        end else if (lhs_k[i] < dn_m_q[i]) begin
          dn_k = 1'b1;
        end else begin
          on_k = 1'b1;
        end
      end
    end
    inside_d = (up_k & dn_k) | on_k;
    on_d = on_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      tol_q <= TolReset;
    end else begin
      v_q <= v_d;
      if (tolerance_we_i) begin
        tol_q <= tolerance_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q[0] <= tri_in;
    for (int k = 1; k < NumStages - 3; k++) begin
      tri_q[k] <= tri_q[k-1];
    end
    e1_b_q <= e1_d;
    e2_b_q <= e2_d;
    prod_c_q <= prod_d;
    nabs_d_q <= nabs_d;
    pp_hh_e_q <= pp_hh_d;
    pp_hl_e_q <= pp_hl_d;
    pp_ll_e_q <= pp_ll_d;
    sq_f_q <= sq_d;
    n2_g_q  <= n2_d;
    tsq_g_q <= tsq_d;
    sq0_g_q <= sq_f_q[0];
    sq1_g_q <= sq_f_q[1];
    rpp_h_q <= rpp_d;
    sq0_h_q <= sq0_g_q;
    sq1_h_q <= sq1_g_q;
    rs0_i_q <= rs0_d;
    rs1_i_q <= rs1_d;
    sq0_i_q <= sq0_h_q;
    sq1_i_q <= sq1_h_q;
    rhs_j_q <= rhs_d;
    sq0_j_q <= sq0_i_q;
    sq1_j_q <= sq1_i_q;
    plane_k_q <= plane_d;
    plane_l_q <= plane_k_q;
    plane_m_q <= plane_l_q;
    dh_l_q  <= dh_d;
    dr_l_q  <= dr_d;
    ad_l_q  <= ad;
    upk_l_q <= upk_d;
    dnk_l_q <= dnk_d;
    use_l_q <= use_d;
    neg_l_q <= neg_d;
    for (int i = 0; i < 3; i++) begin
      lhs_m_q[i] <= dh_l_q[i] * dr_l_q[i];
      up_m_q[i]  <= 70'({{35{upk_l_q[i][34]}}, upk_l_q[i]} * $signed({37'd0, ad_l_q[i]}));
      dn_m_q[i]  <= 70'({{35{dnk_l_q[i][34]}}, dnk_l_q[i]} * $signed({37'd0, ad_l_q[i]}));
    end
    use_m_q <= use_l_q;
    neg_m_q <= neg_l_q;
    inside_res_o <= inside_d;
    on_edge_o    <= on_d;
    plane_used_o <= plane_m_q;
  end

  assign valid_o = v_q[NumStages-1];

endmodule

// File: src/ptip_checker.sv
// Port-level checker for the point-in-triangle pipeline, bound to the top level.
`include "point_in_triangle_projected_macros.svh"

module ptip_checker
  import ptip_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       inside_res_o,
  input logic       on_edge_o,
  input logic [1:0] plane_used_o
);

  `PTIP_ASSERT(a_latency, (start_i && !busy_o) |-> ##NumStages valid_o, "request lost in pipeline")
  `PTIP_ASSERT(a_on_inside, (valid_o && on_edge_o) |-> inside_res_o, "on edge but not inside")
  `PTIP_ASSERT(a_plane, valid_o |-> (plane_used_o == PLANE_YZ || plane_used_o == PLANE_XZ ||
    plane_used_o == PLANE_XY), "bad plane code")

endmodule

bind point_in_triangle_projected ptip_checker u_ptip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .valid_o      (valid_o),
  .inside_res_o (inside_res_o),
  .on_edge_o    (on_edge_o),
  .plane_used_o (plane_used_o)
);
